[hdl/flat_span_texture_mapper_defines.svh]
// ---------------------------------------------------------------------------
// Flat span texture mapper assertion macros
// Shared helpers for the concurrent checks in the block's RTL.
// ---------------------------------------------------------------------------
`ifndef FLAT_SPAN_TEXTURE_MAPPER_DEFINES_SVH
`define FLAT_SPAN_TEXTURE_MAPPER_DEFINES_SVH

// Check on every rising edge outside reset.
`define FSTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included.
`define FSTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/fstm_pkg.sv]
// ---------------------------------------------------------------------------
// Flat span texture mapper package
// Shared constants, codes, types and packing helpers.
// ---------------------------------------------------------------------------
package fstm_pkg;

  localparam int unsigned MAX_SPAN_DEF       = 64;
  localparam int unsigned COLORMAP_COUNT_DEF = 64;
  localparam int unsigned PIXEL_BITS_DEF     = 16;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned LOAD_AW     = 14;
  localparam int unsigned LOAD_VW     = 16;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned MAP_SEL_W   = 6;
  localparam int unsigned LEN_FIELD_W = 7;
  localparam int unsigned SCREEN_W    = 12;
  localparam int unsigned OUT_PIX_W   = 16;
  localparam int unsigned TEXEL_W     = 8;
  localparam int unsigned TEX_AW      = 12;
  localparam int unsigned TEX_DEPTH   = 4096;
  localparam int unsigned CMAP_ROW    = 256;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_TEXEL = 2'd0,
    FUNC_LOAD_CMAP  = 2'd1,
    FUNC_DRAW_SPAN  = 2'd2
  } func_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic               tex_we;
    logic               cmap_we;
    logic [LOAD_AW-1:0] addr;
    logic [LOAD_VW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [TEX_AW-1:0]    spot;
    logic [MAP_SEL_W-1:0] map;
    logic [SCREEN_W-1:0]  col;
    logic                 last;
  } issue_t;

  typedef struct packed {
    logic                 valid;
    logic [OUT_PIX_W-1:0] pixel;
    logic [SCREEN_W-1:0]  col;
    logic                 last;
  } pix_t;

  // Sixteen bits of each coordinate: x in the upper half, y in the lower half.
  function automatic logic [COORD_W-1:0] pack_pair(input logic [COORD_W-1:0] u,
                                                   input logic [COORD_W-1:0] v);
    return {u[21:6], v[21:6]};
  endfunction

  // Texel row from the top six bits of y, column from the top six bits of x.
  function automatic logic [TEX_AW-1:0] texel_spot(input logic [COORD_W-1:0] pos);
    return {pos[15:10], pos[31:26]};
  endfunction

endpackage

[hdl/fstm_req_if.sv]
// ---------------------------------------------------------------------------
// Flat span texture mapper request channel
// Carries load and draw requests with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface fstm_req_if;
  logic                                   valid;
  logic                                   ready;
  logic        [fstm_pkg::FUNC_W-1:0]      func;
  logic        [fstm_pkg::LOAD_AW-1:0]     load_address;
  logic        [fstm_pkg::LOAD_VW-1:0]     load_value;
  logic signed [fstm_pkg::COORD_W-1:0]     start_u;
  logic signed [fstm_pkg::COORD_W-1:0]     start_v;
  logic signed [fstm_pkg::COORD_W-1:0]     step_u;
  logic signed [fstm_pkg::COORD_W-1:0]     step_v;
  logic        [fstm_pkg::MAP_SEL_W-1:0]   map_select;
  logic        [fstm_pkg::LEN_FIELD_W-1:0] span_length;
  logic        [fstm_pkg::SCREEN_W-1:0]    start_column;
  logic        [fstm_pkg::SCREEN_W-1:0]    screen_row;

  modport source (
    output valid, func, load_address, load_value, start_u, start_v, step_u, step_v,
           map_select, span_length, start_column, screen_row,
    input  ready
  );

  modport sink (
    input  valid, func, load_address, load_value, start_u, start_v, step_u, step_v,
           map_select, span_length, start_column, screen_row,
    output ready
  );
endinterface

[hdl/fstm_pix_if.sv]
// ---------------------------------------------------------------------------
// Flat span texture mapper pixel channel
// Carries shaded pixels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface fstm_pix_if;
  logic                             valid;
  logic                             ready;
  logic [fstm_pkg::OUT_PIX_W-1:0]   shaded_pixel;
  logic [fstm_pkg::SCREEN_W-1:0]    pixel_column;
  logic [fstm_pkg::SCREEN_W-1:0]    pixel_row;
  logic                             last_pixel;

  modport source (
    output valid, shaded_pixel, pixel_column, pixel_row, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, shaded_pixel, pixel_column, pixel_row, last_pixel,
    output ready
  );
endinterface

[hdl/fstm_lookup.sv]
// ---------------------------------------------------------------------------
// Flat span texture mapper lookup pipeline
// Texture and colormap memories with two registered read stages.
// ---------------------------------------------------------------------------
module fstm_lookup #(
  parameter int unsigned COLORMAP_COUNT = fstm_pkg::COLORMAP_COUNT_DEF,
  parameter int unsigned PIXEL_BITS     = fstm_pkg::PIXEL_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  fstm_pkg::mem_wr_t wr_i,
  input  fstm_pkg::issue_t  iss_i,
  output fstm_pkg::pix_t    res_o,
  output logic              busy_o
);

  localparam int unsigned MAP_W     = (COLORMAP_COUNT > 1) ? $clog2(COLORMAP_COUNT) : 1;
  localparam int unsigned CMAP_AW   = MAP_W + fstm_pkg::TEXEL_W;
  localparam int unsigned CMAP_DEPTH = COLORMAP_COUNT * fstm_pkg::CMAP_ROW;

  logic [fstm_pkg::TEXEL_W-1:0] tex_mem  [fstm_pkg::TEX_DEPTH];
  logic [PIXEL_BITS-1:0]        cmap_mem [CMAP_DEPTH];

  logic [fstm_pkg::TEXEL_W-1:0]   tex_rd_q;
  logic [PIXEL_BITS-1:0]          cmap_rd_q;
  logic                           s1_valid_q;
  logic                           s2_valid_q;
  logic [MAP_W-1:0]               s1_map_q;
  logic [fstm_pkg::SCREEN_W-1:0]  s1_col_q;
  logic [fstm_pkg::SCREEN_W-1:0]  s2_col_q;
  logic                           s1_last_q;
  logic                           s2_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.tex_we) begin
      tex_mem[wr_i.addr[fstm_pkg::TEX_AW-1:0]] <= wr_i.data[fstm_pkg::TEXEL_W-1:0];
    end
    if (adv_i && iss_i.valid) begin
      tex_rd_q <= tex_mem[iss_i.spot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cmap_we) begin
      cmap_mem[wr_i.addr[CMAP_AW-1:0]] <= wr_i.data[PIXEL_BITS-1:0];
    end
    if (adv_i && s1_valid_q) begin
      cmap_rd_q <= cmap_mem[{s1_map_q, tex_rd_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= iss_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_map_q  <= iss_i.map[MAP_W-1:0];
      s1_col_q  <= iss_i.col;
      s1_last_q <= iss_i.last;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  assign res_o.valid = s2_valid_q;
  assign res_o.pixel = fstm_pkg::OUT_PIX_W'(cmap_rd_q);
  assign res_o.col   = s2_col_q;
  assign res_o.last  = s2_last_q;
  assign busy_o      = s1_valid_q | s2_valid_q;

endmodule

[hdl/flat_span_texture_mapper.sv]
// ---------------------------------------------------------------------------
// Flat span texture mapper
// Draws shaded floor and ceiling spans from a 64x64 texture.
// ---------------------------------------------------------------------------
// A draw request issues one pixel per cycle unless the output stalls, so a
// span of N pixels (clamped to MAX_SPAN) occupies the position adder for its
// N pixels, and the next request is taken only once the texture and colormap
// reads have drained; any cycle with a pixel waiting at the output and not taken
// stalls the whole pipe. The shaded pixel is held in an output register, so the
// last pixel of one span may wait there while the next request is accepted.
`include "flat_span_texture_mapper_defines.svh"

module flat_span_texture_mapper #(
  parameter int unsigned MAX_SPAN       = fstm_pkg::MAX_SPAN_DEF,
  parameter int unsigned COLORMAP_COUNT = fstm_pkg::COLORMAP_COUNT_DEF,
  parameter int unsigned PIXEL_BITS     = fstm_pkg::PIXEL_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fstm_req_if.sink          req_i,
  fstm_pix_if.source        pix_o
);

  localparam int unsigned LEN_W = $clog2(MAX_SPAN + 1);

  fstm_pkg::state_e                 state_q, state_d;
  logic [fstm_pkg::COORD_W-1:0]     pos_q, pos_d;
  logic [fstm_pkg::COORD_W-1:0]     step_q, step_d;
  logic [LEN_W-1:0]                 rem_q, rem_d;
  logic [fstm_pkg::SCREEN_W-1:0]    col_q, col_d;
  logic [fstm_pkg::SCREEN_W-1:0]    row_q, row_d;
  logic [fstm_pkg::MAP_SEL_W-1:0]   map_q, map_d;

  logic                             out_valid_q;
  logic [fstm_pkg::OUT_PIX_W-1:0]   out_pixel_q;
  logic [fstm_pkg::SCREEN_W-1:0]    out_col_q;
  logic [fstm_pkg::SCREEN_W-1:0]    out_row_q;
  logic                             out_last_q;

  logic                             adv;
  logic                             busy;
  logic                             req_acc;
  logic [LEN_W-1:0]                 len_sat;
  logic [fstm_pkg::MAP_SEL_W-1:0]   map_sat;
  fstm_pkg::mem_wr_t                wr;
  fstm_pkg::issue_t                 iss;
  fstm_pkg::pix_t                   res;

  assign adv         = !out_valid_q || pix_o.ready;
  assign req_i.ready = (state_q == fstm_pkg::ST_IDLE) && !busy;
  assign req_acc     = req_i.valid && req_i.ready;

  assign len_sat = (req_i.span_length > fstm_pkg::LEN_FIELD_W'(MAX_SPAN))
                 ? LEN_W'(MAX_SPAN) : req_i.span_length[LEN_W-1:0];
  assign map_sat = ({1'b0, req_i.map_select} >= (fstm_pkg::MAP_SEL_W + 1)'(COLORMAP_COUNT))
                 ? fstm_pkg::MAP_SEL_W'(COLORMAP_COUNT - 1) : req_i.map_select;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    step_d  = step_q;
    rem_d   = rem_q;
    col_d   = col_q;
    row_d   = row_q;
    map_d   = map_q;
    wr      = '0;
    iss     = '0;
    wr.addr = req_i.load_address;
    wr.data = req_i.load_value;
    case (state_q)
      fstm_pkg::ST_IDLE: begin
        if (req_acc) begin
          case (fstm_pkg::func_e'(req_i.func))
            fstm_pkg::FUNC_LOAD_TEXEL: begin
              wr.tex_we = (req_i.load_address[fstm_pkg::LOAD_AW-1:fstm_pkg::TEX_AW] == '0);
            end
            fstm_pkg::FUNC_LOAD_CMAP: begin
              wr.cmap_we = ({1'b0, req_i.load_address[fstm_pkg::LOAD_AW-1:8]}
                            < (fstm_pkg::MAP_SEL_W + 1)'(COLORMAP_COUNT));
            end
            fstm_pkg::FUNC_DRAW_SPAN: begin
              pos_d  = fstm_pkg::pack_pair(req_i.start_u, req_i.start_v);
              step_d = fstm_pkg::pack_pair(req_i.step_u, req_i.step_v);
              rem_d  = len_sat;
              col_d  = req_i.start_column;
              row_d  = req_i.screen_row;
              map_d  = map_sat;
              if (len_sat != '0) begin
                state_d = fstm_pkg::ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      fstm_pkg::ST_RUN: begin
        if (adv) begin
          iss.valid = 1'b1;
          iss.spot  = fstm_pkg::texel_spot(pos_q);
          iss.map   = map_q;
          iss.col   = col_q;
          iss.last  = (rem_q == LEN_W'(1));
          pos_d     = pos_q + step_q;
          col_d     = col_q + fstm_pkg::SCREEN_W'(1);
          rem_d     = rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            state_d = fstm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = fstm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fstm_pkg::ST_IDLE;
      pos_q   <= '0;
      step_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    row_q <= row_d;
    map_q <= map_d;
  end

  fstm_lookup #(
    .COLORMAP_COUNT(COLORMAP_COUNT),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_lookup (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .wr_i  (wr),
    .iss_i (iss),
    .res_o (res),
    .busy_o(busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_pixel_q <= res.pixel;
      out_col_q   <= res.col;
      out_row_q   <= row_q;
      out_last_q  <= res.last;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.shaded_pixel = out_pixel_q;
  assign pix_o.pixel_column = out_col_q;
  assign pix_o.pixel_row    = out_row_q;
  assign pix_o.last_pixel   = out_last_q;

  `FSTM_ASSERT(a_no_request_while_drawing, (state_q == fstm_pkg::ST_RUN) |-> !req_i.ready, "request taken while a span is drawn")
  `FSTM_ASSERT_ALWAYS(a_idle_has_no_pixels_left, (state_q == fstm_pkg::ST_IDLE) |-> (rem_q == '0), "pixels left over in idle")
  `FSTM_ASSERT(a_lookup_holds_on_stall, (res.valid && !adv) |=> res.valid, "lookup result lost during output stall")

endmodule

[test/flat_span_texture_mapper_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flat span texture mapper checker
// Watches the request and pixel channels, keeps its own copy of the texture
// and colormap stores, predicts every shaded pixel of each span request and
// compares each pixel taken from the block with the oldest prediction.
// ---------------------------------------------------------------------------
module flat_span_texture_mapper_checker
  import fstm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fstm_req_if         req_i,
  fstm_pix_if         pix_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned spans_o,
  output int unsigned pixels_o
);

  localparam int unsigned SHADE_DEPTH = COLORMAP_COUNT_DEF * CMAP_ROW;

  typedef struct packed {
    logic [OUT_PIX_W-1:0] pixel;
    logic [SCREEN_W-1:0]  column;
    logic [SCREEN_W-1:0]  row;
    logic                 last;
  } shaded_t;

  logic [TEXEL_W-1:0]   texel_mem [TEX_DEPTH];
  logic [OUT_PIX_W-1:0] shade_mem [SHADE_DEPTH];
  shaded_t              pixel_queue [$];
  shaded_t              oldest;
  int unsigned          errors  = 0;
  int unsigned          spans   = 0;
  int unsigned          pixels  = 0;
  int unsigned          pending = 0;

  assign fail_count_o = errors;
  assign pending_o    = pending;
  assign spans_o      = spans;
  assign pixels_o     = pixels;

  task automatic report(input string field, input logic [OUT_PIX_W-1:0] got,
                        input logic [OUT_PIX_W-1:0] want);
    $display("%0t ns: %s mismatch, got %0h, wanted %0h", $time, field, got, want);
    errors++;
  endtask

  // The 16.16 coordinates keep sixteen bits each in one word, so the carry
  // out of the y half walks into x.
  task automatic shade_span();
    logic [MAP_SEL_W-1:0] map;
    int unsigned          count;
    logic [COORD_W-1:0]   position;
    logic [COORD_W-1:0]   stride;
    logic [TEX_AW-1:0]    spot;
    shaded_t              px;
    map = req_i.map_select;
    if (map >= COLORMAP_COUNT_DEF) begin
      map = MAP_SEL_W'(COLORMAP_COUNT_DEF - 1);
    end
    count    = (req_i.span_length > MAX_SPAN_DEF) ? MAX_SPAN_DEF
                                                  : int'(req_i.span_length);
    position = {req_i.start_u[21:6], req_i.start_v[21:6]};
    stride   = {req_i.step_u[21:6], req_i.step_v[21:6]};
    for (int unsigned k = 0; k < count; k++) begin
      spot      = {position[15:10], position[31:26]};
      px.pixel  = shade_mem[{map, texel_mem[spot]}];
      px.column = req_i.start_column + SCREEN_W'(k);
      px.row    = req_i.screen_row;
      px.last   = (k + 1 == count);
      pixel_queue.push_back(px);
      position += stride;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_i.valid && pix_i.ready) begin
        if (pixel_queue.size() == 0) begin
          report("unrequested pixel", pix_i.shaded_pixel, '0);
        end else begin
          oldest = pixel_queue.pop_front();
          pixels++;
          if (pix_i.shaded_pixel !== oldest.pixel) begin
            report("shaded_pixel", pix_i.shaded_pixel, oldest.pixel);
          end
          if (pix_i.pixel_column !== oldest.column) begin
            report("pixel_column", OUT_PIX_W'(pix_i.pixel_column),
                   OUT_PIX_W'(oldest.column));
          end
          if (pix_i.pixel_row !== oldest.row) begin
            report("pixel_row", OUT_PIX_W'(pix_i.pixel_row), OUT_PIX_W'(oldest.row));
          end
          if (pix_i.last_pixel !== oldest.last) begin
            report("last_pixel", OUT_PIX_W'(pix_i.last_pixel), OUT_PIX_W'(oldest.last));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        case (req_i.func)
          FUNC_LOAD_TEXEL: begin
            if (req_i.load_address < TEX_DEPTH) begin
              texel_mem[req_i.load_address[TEX_AW-1:0]] = req_i.load_value[TEXEL_W-1:0];
            end
          end
          FUNC_LOAD_CMAP: begin
            if ((req_i.load_address >> 8) < COLORMAP_COUNT_DEF) begin
              shade_mem[req_i.load_address] = req_i.load_value[PIXEL_BITS_DEF-1:0];
            end
          end
          FUNC_DRAW_SPAN: begin
            spans++;
            shade_span();
          end
          default: begin
          end
        endcase
      end
      pending <= pixel_queue.size();
    end
  end

endmodule

[test/flat_span_texture_mapper_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flat span texture mapper testbench
// Drives texel loads, colormap loads, span draws and stray requests through
// the request channel under three idling regimes and one long output stall,
// and leaves prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module flat_span_texture_mapper_tb;
  import fstm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam int unsigned SHADE_DEPTH  = COLORMAP_COUNT_DEF * CMAP_ROW;

  typedef enum int {
    PHASE_SLOW_SINK,
    PHASE_SLOW_SOURCE,
    PHASE_FREE
  } phase_e;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [LOAD_AW-1:0]     load_address;
    logic [LOAD_VW-1:0]     load_value;
    logic [COORD_W-1:0]     start_u;
    logic [COORD_W-1:0]     start_v;
    logic [COORD_W-1:0]     step_u;
    logic [COORD_W-1:0]     step_v;
    logic [MAP_SEL_W-1:0]   map_select;
    logic [LEN_FIELD_W-1:0] span_length;
    logic [SCREEN_W-1:0]    start_column;
    logic [SCREEN_W-1:0]    screen_row;
  } request_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned spans;
  int unsigned pixels;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle  = 25;
  int unsigned recv_idle  = 83;
  int unsigned hold_count = 0;
  int unsigned random_start;
  phase_e      phase      = PHASE_SLOW_SINK;

  // Stimulus-side record of what has been written, so that no span ever
  // reads a texel or colormap entry that was never loaded.
  logic [TEXEL_W-1:0] texel_shadow [TEX_DEPTH];
  bit                 texel_known  [TEX_DEPTH];
  bit                 shade_known  [SHADE_DEPTH];

  fstm_req_if req_bus ();
  fstm_pix_if pix_bus ();

  flat_span_texture_mapper u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .pix_o  (pix_bus)
  );

  flat_span_texture_mapper_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_bus),
    .pix_i        (pix_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .spans_o      (spans),
    .pixels_o     (pixels)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic request_t filler();
    request_t r;
    r.func         = FUNC_RESERVED;
    r.load_address = LOAD_AW'($urandom);
    r.load_value   = LOAD_VW'($urandom);
    r.start_u      = $urandom;
    r.start_v      = $urandom;
    r.step_u       = $urandom;
    r.step_v       = $urandom;
    r.map_select   = MAP_SEL_W'($urandom);
    r.span_length  = LEN_FIELD_W'($urandom);
    r.start_column = SCREEN_W'($urandom);
    r.screen_row   = SCREEN_W'($urandom);
    return r;
  endfunction

  task automatic send(input request_t r);
    while ($urandom_range(99) < send_idle) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.func         <= r.func;
    req_bus.load_address <= r.load_address;
    req_bus.load_value   <= r.load_value;
    req_bus.start_u      <= r.start_u;
    req_bus.start_v      <= r.start_v;
    req_bus.step_u       <= r.step_u;
    req_bus.step_v       <= r.step_v;
    req_bus.map_select   <= r.map_select;
    req_bus.span_length  <= r.span_length;
    req_bus.start_column <= r.start_column;
    req_bus.screen_row   <= r.screen_row;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic load_texel(input logic [LOAD_AW-1:0] addr, input logic [LOAD_VW-1:0] value);
    request_t r;
    r              = filler();
    r.func         = FUNC_LOAD_TEXEL;
    r.load_address = addr;
    r.load_value   = value;
    send(r);
    if (addr < TEX_DEPTH) begin
      texel_shadow[addr[TEX_AW-1:0]] = value[TEXEL_W-1:0];
      texel_known[addr[TEX_AW-1:0]]  = 1'b1;
    end
  endtask

  task automatic load_shade(input logic [LOAD_AW-1:0] addr, input logic [LOAD_VW-1:0] value);
    request_t r;
    r              = filler();
    r.func         = FUNC_LOAD_CMAP;
    r.load_address = addr;
    r.load_value   = value;
    send(r);
    if ((addr >> 8) < COLORMAP_COUNT_DEF) begin
      shade_known[addr] = 1'b1;
    end
  endtask

  // Loads whatever the span is about to read, then issues the draw itself.
  task automatic draw(input logic [COORD_W-1:0] su, input logic [COORD_W-1:0] sv,
                      input logic [COORD_W-1:0] du, input logic [COORD_W-1:0] dv,
                      input logic [MAP_SEL_W-1:0] map, input logic [LEN_FIELD_W-1:0] len,
                      input logic [SCREEN_W-1:0] col, input logic [SCREEN_W-1:0] row);
    request_t           r;
    logic [COORD_W-1:0] position;
    logic [COORD_W-1:0] stride;
    logic [TEX_AW-1:0]  spot;
    logic [LOAD_AW-1:0] entry;
    int unsigned        count;
    count    = (len > MAX_SPAN_DEF) ? MAX_SPAN_DEF : int'(len);
    position = {su[21:6], sv[21:6]};
    stride   = {du[21:6], dv[21:6]};
    for (int unsigned k = 0; k < count; k++) begin
      spot = {position[15:10], position[31:26]};
      if (!texel_known[spot]) begin
        load_texel({2'b00, spot}, LOAD_VW'($urandom));
      end
      entry = {map, texel_shadow[spot]};
      if (!shade_known[entry]) begin
        load_shade(entry, LOAD_VW'($urandom));
      end
      position += stride;
    end
    r              = filler();
    r.func         = FUNC_DRAW_SPAN;
    r.start_u      = su;
    r.start_v      = sv;
    r.step_u       = du;
    r.step_v       = dv;
    r.map_select   = map;
    r.span_length  = len;
    r.start_column = col;
    r.screen_row   = row;
    send(r);
  endtask

  task automatic noise();
    request_t r;
    case ($urandom_range(2))
      0: begin
        r = filler();
        send(r);
      end
      1: load_texel(LOAD_AW'($urandom), LOAD_VW'($urandom));
      default: load_shade(LOAD_AW'($urandom), LOAD_VW'($urandom));
    endcase
  endtask

  task automatic random_draw();
    logic [COORD_W-1:0] du;
    logic [COORD_W-1:0] dv;
    int unsigned        pick;
    int unsigned        len;
    pick = $urandom_range(99);
    if (pick < 10) begin
      len = 0;
    end else if (pick < 70) begin
      len = $urandom_range(1, 8);
    end else if (pick < 85) begin
      len = $urandom_range(9, 63);
    end else if (pick < 93) begin
      len = MAX_SPAN_DEF;
    end else begin
      len = $urandom_range(MAX_SPAN_DEF + 1, 127);
    end
    if ($urandom_range(1)) begin
      du = $urandom;
      dv = $urandom;
    end else begin
      du = $urandom_range(32'h0003_0000);
      dv = $urandom_range(32'h0003_0000);
      if ($urandom_range(1)) du = -du;
      if ($urandom_range(1)) dv = -dv;
    end
    draw($urandom, $urandom, du, dv, MAP_SEL_W'($urandom), LEN_FIELD_W'(len),
         SCREEN_W'($urandom), SCREEN_W'($urandom));
  endtask

  // One long stall at the start of the free-running phase backs the block up.
  always @(posedge clk_i) begin
    if (phase == PHASE_FREE && hold_count < HOLD_CYCLES) begin
      pix_bus.ready <= 1'b0;
      hold_count++;
    end else begin
      pix_bus.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("flat_span_texture_mapper_tb failed");
      $finish;
    end
  end

  initial begin
    req_bus.valid        = 1'b0;
    req_bus.func         = '0;
    req_bus.load_address = '0;
    req_bus.load_value   = '0;
    req_bus.start_u      = '0;
    req_bus.start_v      = '0;
    req_bus.step_u       = '0;
    req_bus.step_v       = '0;
    req_bus.map_select   = '0;
    req_bus.span_length  = '0;
    req_bus.start_column = '0;
    req_bus.screen_row   = '0;
    rst_ni               = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    noise();
    load_texel(14'd4095, 16'hffff);
    load_texel(14'd0, 16'h0000);
    load_texel(14'h3fff, LOAD_VW'($urandom));
    load_texel(14'd4096, LOAD_VW'($urandom));
    load_shade(14'h3fff, 16'hffff);
    load_shade(14'd0, 16'h0000);
    draw(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 6'd0, 7'd0,
         12'd0, 12'd0);
    draw(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 6'd0, 7'd1,
         12'd0, 12'd0);
    draw(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0040, 32'h0000_0000, 6'd63, 7'd127,
         12'd4095, 12'd4095);
    draw(32'h0000_0000, 32'h0000_0040, 32'h0000_0000, 32'h003f_ffc0, 6'd5, 7'd4,
         12'd100, 12'd7);
    draw(32'h0010_0000, 32'h0020_0000, 32'hffff_0000, 32'hffff_8000, 6'd33, 7'd8,
         12'd4090, 12'd2048);
    draw($urandom, $urandom, 32'h0000_1000, 32'hffff_f000, 6'd62, 7'd64,
         12'd1, 12'd4094);

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if (phase == PHASE_SLOW_SINK && items_sent >= random_start + RANDOM_ITEMS / 3) begin
        phase     = PHASE_SLOW_SOURCE;
        send_idle = 83;
        recv_idle = 25;
      end else if (phase == PHASE_SLOW_SOURCE &&
                   items_sent >= random_start + 2 * RANDOM_ITEMS / 3) begin
        phase     = PHASE_FREE;
        send_idle = 0;
        recv_idle = 0;
        repeat (4) begin
          draw('0, '0, '0, '0, MAP_SEL_W'($urandom), 7'd64, SCREEN_W'($urandom),
               SCREEN_W'($urandom));
        end
      end
      if ($urandom_range(99) < 15) begin
        noise();
      end else begin
        random_draw();
      end
    end
    req_bus.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests, %0d of them span draws, and checked %0d shaded pixels,",
             items_sent, spans, pixels);
    $display("under slow-sink, slow-source and free-running handshakes and a long stall.");
    if (fail_count == 0) begin
      $display("flat_span_texture_mapper_tb passed");
    end else begin
      $display("flat_span_texture_mapper_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/fstm_pkg.sv
hdl/fstm_req_if.sv
hdl/fstm_pix_if.sv
hdl/fstm_lookup.sv
hdl/flat_span_texture_mapper.sv
test/flat_span_texture_mapper_checker.sv
test/flat_span_texture_mapper_tb.sv
